### rtl/core/mmv_pkg.sv
// Shared types and constants for the masked mean/variance block.
// Used by every module under rtl/core; depends on nothing else.
package mmv_pkg;

   localparam int unsigned SAMPLE_WIDTH = 16;
   localparam int unsigned COUNT_WIDTH  = 13;
   localparam int unsigned SUM_WIDTH    = 28;
   localparam int unsigned SQSUM_WIDTH  = 44;
   localparam int unsigned MEAN_WIDTH   = 24;
   localparam int unsigned VAR_WIDTH    = 38;

   localparam int unsigned SQ_SPLIT     = 22;
   localparam int unsigned PART_WIDTH   = COUNT_WIDTH + SQ_SPLIT;
   localparam int unsigned SQPROD_WIDTH = SUM_WIDTH * 2;
   localparam int unsigned DIFF_WIDTH   = COUNT_WIDTH + SQSUM_WIDTH;
   localparam int unsigned NN_WIDTH     = COUNT_WIDTH * 2;
   localparam int unsigned FRAC_BITS    = 8;
   localparam int unsigned NUM_WIDTH    = DIFF_WIDTH + FRAC_BITS;
   localparam int unsigned DIV_STEPS    = NUM_WIDTH;
   localparam int unsigned STEP_WIDTH   = $clog2(DIV_STEPS);

   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam logic [SAMPLE_WIDTH-1:0] SENTINEL_RESET = 16'hFFFF;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [SUM_WIDTH-1:0]   total;
      logic [SQSUM_WIDTH-1:0] square_total;
      logic                   overflow;
   } window_stats_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_ADD,
      BK_SUB,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

### rtl/core/mmv_front.sv
// Front end: takes requests, skips sentinel samples and accumulates count,
// sum and sum of squares; hands a window snapshot to the queue on tlast.
// Depends on mmv_pkg.
module mmv_front
   import mmv_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [15:0]             req_tdata,   // sample[15:0]
   input  logic                    req_tlast,   // window_end
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [SAMPLE_WIDTH-1:0] csr_data,    // sentinel_value[15:0]
   output logic                    push,
   output window_stats_type        push_data
);

   logic [SAMPLE_WIDTH-1:0]   sentinel_ff, sentinel_in;
   window_stats_type          stats_ff, stats_in;
   window_stats_type          stats_upd;
   logic [SAMPLE_WIDTH-1:0]   sample;
   logic [2*SAMPLE_WIDTH-1:0] square;
   logic                      accept;

   assign csr_ready = 1'b1;
   assign sample    = req_tdata[SAMPLE_WIDTH-1:0];
   assign square    = sample * sample;
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      sentinel_in = sentinel_ff;
      if (csr_valid && csr_ready) begin
         sentinel_in = csr_data;
      end
   end

   always_comb begin
      stats_upd = stats_ff;
      if (sample != sentinel_ff) begin
         if (32'(stats_ff.count) >= MAX_SAMPLES) begin
            stats_upd.overflow = 1'b1;
         end else begin
            stats_upd.total        = stats_ff.total + SUM_WIDTH'(sample);
            stats_upd.square_total = stats_ff.square_total + SQSUM_WIDTH'(square);
            stats_upd.count        = stats_ff.count + 1'b1;
         end
      end
   end

   assign push      = accept && req_tlast;
   assign push_data = stats_upd;

   always_comb begin
      stats_in = stats_ff;
      if (push) begin
         stats_in = '0;
      end else if (accept) begin
         stats_in = stats_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sentinel_ff <= SENTINEL_RESET;
         stats_ff    <= '0;
      end else begin
         sentinel_ff <= sentinel_in;
         stats_ff    <= stats_in;
      end
   end

endmodule

### rtl/core/mmv_queue.sv
// Short queue of window snapshots between front end and back end.
// Depends on mmv_pkg.
module mmv_queue
   import mmv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  window_stats_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output window_stats_type pop_data
);

   localparam int unsigned PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(QUEUE_DEPTH - 1);

   window_stats_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/mmv_back.sv
// Back end: forms n*sumsq - sum^2 and n^2 from a window snapshot, runs
// restoring division for mean and variance, and holds the response.
// Depends on mmv_pkg.
module mmv_back
   import mmv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  window_stats_type in_data,
   output logic             in_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [79:0]      rsp_tdata,   // valid_count[12:0], mean_q8[36:13],
                                         // variance_q8[74:37], zero[79:75]
   output logic             rsp_tuser    // count_overflow
);

   back_state_type           state_ff, state_in;
   logic                     load_out;
   logic                     div_last;

   window_stats_type         stats_ff, stats_in;
   logic [PART_WIDTH-1:0]    plo_ff, plo_in;
   logic [PART_WIDTH-1:0]    phi_ff, phi_in;
   logic [SQPROD_WIDTH-1:0]  b_ff, b_in;
   logic [NN_WIDTH-1:0]      nn_ff, nn_in;
   logic [DIFF_WIDTH-1:0]    a_ff, a_in;
   logic [NUM_WIDTH-1:0]     var_num_ff, var_num_in;
   logic [NUM_WIDTH-1:0]     mean_num_ff, mean_num_in;
   logic [NN_WIDTH-1:0]      var_rem_ff, var_rem_in;
   logic [COUNT_WIDTH-1:0]   mean_rem_ff, mean_rem_in;
   logic [VAR_WIDTH-1:0]     var_q_ff, var_q_in;
   logic [MEAN_WIDTH-1:0]    mean_q_ff, mean_q_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]   out_count_ff, out_count_in;
   logic [MEAN_WIDTH-1:0]    out_mean_ff, out_mean_in;
   logic [VAR_WIDTH-1:0]     out_var_ff, out_var_in;
   logic                     out_ovf_ff, out_ovf_in;

   logic [DIFF_WIDTH-1:0]    b_wide;
   logic [DIFF_WIDTH-1:0]    diff;
   logic [NN_WIDTH:0]        var_trial;
   logic                     var_ge;
   logic [COUNT_WIDTH:0]     mean_trial;
   logic                     mean_ge;

   assign div_last = (step_ff == STEP_WIDTH'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (in_valid) state_in = BK_MUL;
         BK_MUL:  state_in = BK_ADD;
         BK_ADD:  state_in = BK_SUB;
         BK_SUB:  state_in = BK_DIV;
         BK_DIV:  if (div_last) state_in = BK_DONE;
         BK_DONE: if (load_out) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      in_pop   = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: in_pop = in_valid;
         BK_DONE: load_out = !rsp_valid_ff || rsp_tready;
         default: begin
            in_pop   = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   assign b_wide     = DIFF_WIDTH'(b_ff);
   assign diff       = (a_ff >= b_wide) ? (a_ff - b_wide) : '0;
   assign var_trial  = {var_rem_ff, var_num_ff[NUM_WIDTH-1]};
   assign var_ge     = (var_trial >= {1'b0, nn_ff});
   assign mean_trial = {mean_rem_ff, mean_num_ff[NUM_WIDTH-1]};
   assign mean_ge    = (mean_trial >= {1'b0, stats_ff.count});

   always_comb begin
      stats_in    = stats_ff;
      plo_in      = plo_ff;
      phi_in      = phi_ff;
      b_in        = b_ff;
      nn_in       = nn_ff;
      a_in        = a_ff;
      var_num_in  = var_num_ff;
      mean_num_in = mean_num_ff;
      var_rem_in  = var_rem_ff;
      mean_rem_in = mean_rem_ff;
      var_q_in    = var_q_ff;
      mean_q_in   = mean_q_ff;
      step_in     = step_ff;
      if (in_pop) begin
         stats_in = in_data;
      end
      if (state_ff == BK_MUL) begin
         plo_in = stats_ff.count * stats_ff.square_total[SQ_SPLIT-1:0];
         phi_in = stats_ff.count * stats_ff.square_total[SQSUM_WIDTH-1:SQ_SPLIT];
         b_in   = stats_ff.total * stats_ff.total;
         nn_in  = stats_ff.count * stats_ff.count;
      end
      if (state_ff == BK_ADD) begin
         a_in = DIFF_WIDTH'(plo_ff) + (DIFF_WIDTH'(phi_ff) << SQ_SPLIT);
      end
      if (state_ff == BK_SUB) begin
         var_num_in  = {diff, {FRAC_BITS{1'b0}}};
         mean_num_in = NUM_WIDTH'({stats_ff.total, {FRAC_BITS{1'b0}}});
         var_rem_in  = '0;
         mean_rem_in = '0;
         var_q_in    = '0;
         mean_q_in   = '0;
         step_in     = '0;
      end
      if (state_ff == BK_DIV) begin
         var_num_in  = var_num_ff << 1;
         mean_num_in = mean_num_ff << 1;
         var_rem_in  = var_ge ? NN_WIDTH'(var_trial - {1'b0, nn_ff})
                              : var_trial[NN_WIDTH-1:0];
         mean_rem_in = mean_ge ? COUNT_WIDTH'(mean_trial - {1'b0, stats_ff.count})
                               : mean_trial[COUNT_WIDTH-1:0];
         var_q_in    = {var_q_ff[VAR_WIDTH-2:0], var_ge};
         mean_q_in   = {mean_q_ff[MEAN_WIDTH-2:0], mean_ge};
         step_in     = step_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_count_in = out_count_ff;
      out_mean_in  = out_mean_ff;
      out_var_in   = out_var_ff;
      out_ovf_in   = out_ovf_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_count_in = stats_ff.count;
         out_ovf_in   = stats_ff.overflow;
         out_mean_in  = (stats_ff.count == '0) ? '0 : mean_q_ff;
         out_var_in   = (stats_ff.count == '0) ? '0 : var_q_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stats_ff     <= stats_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      b_ff         <= b_in;
      nn_ff        <= nn_in;
      a_ff         <= a_in;
      var_num_ff   <= var_num_in;
      mean_num_ff  <= mean_num_in;
      var_rem_ff   <= var_rem_in;
      mean_rem_ff  <= mean_rem_in;
      var_q_ff     <= var_q_in;
      mean_q_ff    <= mean_q_in;
      step_ff      <= step_in;
      out_count_ff <= out_count_in;
      out_mean_ff  <= out_mean_in;
      out_var_ff   <= out_var_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, out_var_ff, out_mean_ff, out_count_ff};
   assign rsp_tuser  = out_ovf_ff;

   a_var_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && nn_ff != '0) |-> (var_rem_ff < nn_ff))
      else $error("variance remainder not below n*n");

   a_mean_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV && stats_ff.count != '0) |-> (mean_rem_ff < stats_ff.count))
      else $error("mean remainder not below n");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == BK_DONE))
      else $error("response overwritten before it was taken");

endmodule

### rtl/core/masked_mean_variance.sv
// Windowed mean and population variance of 16-bit samples that skips a
// configurable sentinel value. Samples enter at one per cycle; on each
// window's last sample a snapshot of count, sum and sum of squares goes
// into a two-entry queue. The back end then takes each window through
// capture, multiply, add and subtract states, 65 restoring division steps
// for the mean and variance quotients and a load of the response register,
// so a stream of short windows can fill the queue, and req_tready falls
// until the back end catches up. Results are exact Q8 floor values.
module masked_mean_variance
   import mmv_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample[15:0]
   input  logic        req_tlast,   // window_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // valid_count[12:0], mean_q8[36:13],
                                    // variance_q8[74:37], zero[79:75]
   output logic        rsp_tuser,   // count_overflow
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // sentinel_value[15:0]
);

   logic             push;
   window_stats_type push_data;
   logic             queue_full;
   logic             queue_pop;
   logic             queue_valid;
   window_stats_type queue_data;

   assign req_tready = !queue_full;

   mmv_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push       (push),
      .push_data  (push_data)
   );

   mmv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .pop_data  (queue_data)
   );

   mmv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_data    (queue_data),
      .in_pop     (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for masked_mean_variance: streams sample windows,
// predicts count, mean, variance and overflow per window and checks each response.
// Depends on mmv_pkg and the masked_mean_variance RTL only.
module tb_top
   import mmv_pkg::*;
();

   localparam int unsigned MAX_SAMPLES = 4096;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned LONG_STALL = 600;
   localparam int unsigned RANDOM_ITEMS = 1000;

   typedef struct {
      bit [COUNT_WIDTH-1:0] count;
      bit [MEAN_WIDTH-1:0]  mean_q8;
      bit [VAR_WIDTH-1:0]   variance_q8;
      bit                   overflow;
   } window_result_type;

   class mmv_scoreboard;
      bit [SAMPLE_WIDTH-1:0] sentinel_value = SENTINEL_RESET;
      bit [SUM_WIDTH-1:0]    total;
      bit [SQSUM_WIDTH-1:0]  square_total;
      bit [COUNT_WIDTH-1:0]  count;
      bit                    overflow;
      window_result_type     pending_results[$];
      int                    errors;
      int                    requests_seen;
      int                    windows_checked;
      int                    full_windows;
      int                    overflow_windows;
      int                    empty_windows;

      function void set_sentinel(bit [SAMPLE_WIDTH-1:0] value);
         sentinel_value = value;
      endfunction

      function void note_request(bit [SAMPLE_WIDTH-1:0] sample, bit window_end);
         bit [127:0]        n, nn, a, b, d, q, r, mean, spread;
         window_result_type result;
         requests_seen++;
         if (sample != sentinel_value) begin
            if (count >= MAX_SAMPLES) begin
               overflow = 1'b1;
            end else begin
               total = total + sample;
               square_total = square_total + SQSUM_WIDTH'(sample) * SQSUM_WIDTH'(sample);
               count = count + 1'b1;
            end
         end
         if (!window_end) return;
         n = count;
         mean = 0;
         spread = 0;
         if (n != 0) begin
            nn = n * n;
            a = n * square_total;
            b = 128'(total) * 128'(total);
            d = (a >= b) ? a - b : 0;
            q = d / nn;
            r = d % nn;
            mean = (128'(total) << FRAC_BITS) / n;
            spread = (q << FRAC_BITS) + ((r << FRAC_BITS) / nn);
         end
         result.count = count;
         result.mean_q8 = mean[MEAN_WIDTH-1:0];
         result.variance_q8 = spread[VAR_WIDTH-1:0];
         result.overflow = overflow;
         pending_results.push_back(result);
         total = 0;
         square_total = 0;
         count = 0;
         overflow = 0;
      endfunction

      function void check_result(logic [79:0] data, logic flag);
         window_result_type want;
         if (pending_results.size() == 0) begin
            $error("response with no window pending: tdata=%h tuser=%b", data, flag);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         windows_checked++;
         if (want.count == MAX_SAMPLES) full_windows++;
         if (want.overflow) overflow_windows++;
         if (want.count == 0) empty_windows++;
         if (data[12:0] !== want.count) begin
            $error("valid_count: expected %0d, actual %0d", want.count, data[12:0]);
            errors++;
         end
         if (data[36:13] !== want.mean_q8) begin
            $error("mean_q8: expected %0d, actual %0d", want.mean_q8, data[36:13]);
            errors++;
         end
         if (data[74:37] !== want.variance_q8) begin
            $error("variance_q8: expected %0d, actual %0d", want.variance_q8, data[74:37]);
            errors++;
         end
         if (data[79:75] !== 5'd0) begin
            $error("padding: expected 0, actual %b", data[79:75]);
            errors++;
         end
         if (flag !== want.overflow) begin
            $error("count_overflow: expected %0d, actual %b", want.overflow, flag);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   mmv_scoreboard sb = new();
   bit            steady;
   bit            long_stall_done;
   int            settings_used;

   masked_mean_variance #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit [15:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return sb.sentinel_value;
      if (roll < 30) return 16'h0000;
      if (roll < 40) return 16'hFFFF;
      if (roll < 50) return 16'($urandom_range(0, 15));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_request(bit [15:0] sample, bit window_end);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      req_tlast <= window_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(sample, window_end);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sentinel(bit [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_sentinel(value);
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_window(int length, bit all_skipped);
      for (int i = 0; i < length; i++) begin
         send_request(all_skipped ? sb.sentinel_value : pick_sample(), i == length - 1);
      end
   endtask

   task automatic send_long_window(int valid_total);
      int        sent_valid;
      bit [15:0] sample;
      sent_valid = 0;
      while (sent_valid < valid_total) begin
         if ($urandom_range(0, 9) == 0) begin
            sample = sb.sentinel_value;
         end else begin
            sample = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(49152, 65535));
            if (sample == sb.sentinel_value) sample = ~sample;
            sent_valid++;
         end
         send_request(sample, sample != sb.sentinel_value && sent_valid == valid_total);
      end
   endtask

   task automatic run_random_segment(int items, bit pause_midway);
      int start;
      int roll;
      start = sb.requests_seen;
      while (sb.requests_seen - start < items) begin
         if (pause_midway && sb.requests_seen - start >= items / 2) begin
            pause_midway = 0;
            wait_drained();
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) send_window($urandom_range(1, 4), 1'b1);
         else if (roll < 15) send_window(1, 1'b0);
         else if (roll < 75) send_window($urandom_range(2, 12), 1'b0);
         else if (roll < 95) send_window($urandom_range(13, 60), 1'b0);
         else send_window($urandom_range(61, 300), 1'b0);
      end
   endtask

   initial begin
      int ready_hold;
      ready_hold = 0;
      forever begin
         @(negedge clock);
         if (!long_stall_done && steady) begin
            long_stall_done = 1;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
         end
         if (ready_hold == 0 && !steady && $urandom_range(0, 9) == 0) ready_hold = pick_gap();
         if (ready_hold > 0) begin
            rsp_tready <= 1'b0;
            ready_hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser);
            ready_hold = pick_gap();
         end
      end
   end

   initial begin
      settings_used = 1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // sentinel at reset value, then at zero
      send_request(16'h0000, 1'b1);
      send_request(16'hFFFF, 1'b1);
      send_request(16'hFFFE, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'hFFFE, 1'b1);
      send_request(16'hAAAA, 1'b0);
      send_request(16'h5555, 1'b0);
      send_request(16'hFFFF, 1'b1);
      send_request(16'd12345, 1'b0);
      send_request(16'd12345, 1'b0);
      send_request(16'd12345, 1'b1);
      write_sentinel(16'h0000);
      send_request(16'hFFFF, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0000, 1'b1);
      send_request(16'h0000, 1'b1);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0001, 1'b1);

      // capacity: exactly full, then past the limit
      write_sentinel(16'h1234);
      send_long_window(MAX_SAMPLES);
      send_long_window(MAX_SAMPLES + 3);

      write_sentinel(16'($urandom_range(0, 65535)));
      run_random_segment(RANDOM_ITEMS / 4, 1'b0);
      write_sentinel(16'hFFFF);
      steady = 1;
      run_random_segment(RANDOM_ITEMS / 4, 1'b0);
      steady = 0;
      write_sentinel(16'h0000);
      run_random_segment(RANDOM_ITEMS / 4, 1'b1);
      write_sentinel(16'($urandom_range(0, 65535)));
      run_random_segment(RANDOM_ITEMS / 4, 1'b0);

      wait_drained();
      $display("Checked %0d windows from %0d requests under %0d sentinel settings",
               sb.windows_checked, sb.requests_seen, settings_used);
      $display("including %0d empty, %0d full and %0d overflowing windows",
               sb.empty_windows, sb.full_windows, sb.overflow_windows);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $error("timeout with %0d windows still pending", sb.pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
